### rtl/sswpi_pkg.sv
// Package for the skid-steer wheel PI controller.
// Holds number formats, microcode word layout, register indexes and the microcode ROM.
// No dependencies.
package sswpi_pkg;

    localparam int VALUE_WIDTH     = 32;
    localparam int FRACTION_BITS   = 16;
    localparam int WHEEL_COUNT     = 4;
    localparam int GAIN_WIDTH      = 31;
    localparam int STEP_WIDTH      = 5;
    localparam int WHEEL_IDX_WIDTH = 2;
    localparam int CFG_ADDR_WIDTH  = 5;
    localparam int CFG_DATA_WIDTH  = 32;
    localparam int IN_DATA_WIDTH   = 6 * VALUE_WIDTH;
    localparam int OUT_DATA_WIDTH  = 10 * VALUE_WIDTH;
    localparam int PROD_WIDTH      = GAIN_WIDTH + VALUE_WIDTH;

    typedef logic signed [VALUE_WIDTH-1:0] value_t;
    typedef logic [GAIN_WIDTH-1:0]         gain_t;
    typedef logic [STEP_WIDTH-1:0]         step_t;
    typedef logic [WHEEL_IDX_WIDTH-1:0]    wheel_t;

    localparam value_t VMAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
    localparam value_t VMIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

    localparam gain_t  ONE_Q        = gain_t'(1) << FRACTION_BITS;
    localparam gain_t  WHEEL_RESET  = gain_t'(10) << FRACTION_BITS;
    localparam wheel_t WHEEL_LAST   = wheel_t'(WHEEL_COUNT - 1);

    typedef enum logic [3:0] {
        OP_NOP, OP_MUL, OP_RND, OP_ADD, OP_SUB, OP_CLAMPW, OP_CLAMPI, OP_CLAMPE,
        OP_LATCH, OP_JKIZ, OP_LOOP, OP_DONE
    } op_t;

    typedef enum logic [3:0] {
        SRC_LIN, SRC_ANG, SRC_A, SRC_B, SRC_T, SRC_ERR, SRC_P, SRC_INTEG, SRC_TGT, SRC_SPD
    } src_t;

    typedef enum logic [3:0] {
        DST_NONE, DST_A, DST_B, DST_T, DST_RIGHT, DST_LEFT, DST_ERR, DST_P, DST_INTEG, DST_TORQ
    } dst_t;

    typedef enum logic [1:0] {GAIN_KP, GAIN_KI, GAIN_LIN, GAIN_TURN} gsel_t;

    typedef enum logic [2:0] {
        REG_KP, REG_KI, REG_ILOW, REG_IHIGH, REG_EFFORT, REG_LIN, REG_TURN, REG_WSB
    } reg_idx_t;

    typedef enum logic {ST_IDLE, ST_RUN} state_t;

    typedef struct packed {
        op_t   op;
        src_t  src_x;
        src_t  src_y;
        dst_t  dst;
        gsel_t gain;
        step_t target;
    } uword_t;

    typedef struct packed {
        uword_t uw;
        wheel_t wheel;
        logic   start;
        logic   load_out;
    } dp_ctrl_t;

    typedef struct packed {
        gain_t  kp;
        gain_t  ki;
        value_t ilow;
        gain_t  ihigh;
        gain_t  effort;
        gain_t  lin_scale;
        gain_t  turn_scale;
        gain_t  wheel_bound;
    } cfg_t;

    localparam step_t STEP_WHEEL  = step_t'(9);
    localparam step_t STEP_TORQUE = step_t'(17);

    function automatic uword_t uw(op_t op, src_t x, src_t y, dst_t d, gsel_t g, step_t t);
        uword_t w;
        w.op     = op;
        w.src_x  = x;
        w.src_y  = y;
        w.dst    = d;
        w.gain   = g;
        w.target = t;
        return w;
    endfunction

    // Microcode ROM
    function automatic uword_t ucode(step_t s);
        uword_t w;
        w = uw(OP_DONE, SRC_LIN, SRC_LIN, DST_NONE, GAIN_KP, '0);
        case (s)
            step_t'(0):  w = uw(OP_MUL,    SRC_LIN,   SRC_LIN,   DST_NONE,  GAIN_LIN,  '0);
            step_t'(1):  w = uw(OP_RND,    SRC_LIN,   SRC_LIN,   DST_A,     GAIN_KP,   '0);
            step_t'(2):  w = uw(OP_MUL,    SRC_ANG,   SRC_LIN,   DST_NONE,  GAIN_TURN, '0);
            step_t'(3):  w = uw(OP_RND,    SRC_LIN,   SRC_LIN,   DST_B,     GAIN_KP,   '0);
            step_t'(4):  w = uw(OP_ADD,    SRC_A,     SRC_B,     DST_T,     GAIN_KP,   '0);
            step_t'(5):  w = uw(OP_CLAMPW, SRC_T,     SRC_LIN,   DST_RIGHT, GAIN_KP,   '0);
            step_t'(6):  w = uw(OP_SUB,    SRC_A,     SRC_B,     DST_T,     GAIN_KP,   '0);
            step_t'(7):  w = uw(OP_CLAMPW, SRC_T,     SRC_LIN,   DST_LEFT,  GAIN_KP,   '0);
            step_t'(8):  w = uw(OP_LATCH,  SRC_LIN,   SRC_LIN,   DST_NONE,  GAIN_KP,   '0);
            step_t'(9):  w = uw(OP_SUB,    SRC_TGT,   SRC_SPD,   DST_ERR,   GAIN_KP,   '0);
            step_t'(10): w = uw(OP_MUL,    SRC_ERR,   SRC_LIN,   DST_NONE,  GAIN_KP,   '0);
            step_t'(11): w = uw(OP_RND,    SRC_LIN,   SRC_LIN,   DST_P,     GAIN_KP,   '0);
            step_t'(12): w = uw(OP_JKIZ,   SRC_LIN,   SRC_LIN,   DST_NONE,  GAIN_KP,
                                STEP_TORQUE);
            step_t'(13): w = uw(OP_MUL,    SRC_ERR,   SRC_LIN,   DST_NONE,  GAIN_KI,   '0);
            step_t'(14): w = uw(OP_RND,    SRC_LIN,   SRC_LIN,   DST_T,     GAIN_KP,   '0);
            step_t'(15): w = uw(OP_ADD,    SRC_INTEG, SRC_T,     DST_T,     GAIN_KP,   '0);
            step_t'(16): w = uw(OP_CLAMPI, SRC_T,     SRC_LIN,   DST_INTEG, GAIN_KP,   '0);
            step_t'(17): w = uw(OP_ADD,    SRC_P,     SRC_INTEG, DST_T,     GAIN_KP,   '0);
            step_t'(18): w = uw(OP_CLAMPE, SRC_T,     SRC_LIN,   DST_TORQ,  GAIN_KP,   '0);
            step_t'(19): w = uw(OP_LOOP,   SRC_LIN,   SRC_LIN,   DST_NONE,  GAIN_KP,
                                STEP_WHEEL);
            default:     w = uw(OP_DONE,   SRC_LIN,   SRC_LIN,   DST_NONE,  GAIN_KP,   '0);
        endcase
        return w;
    endfunction

    function automatic value_t sat_add(value_t a, value_t b, logic sub);
        logic signed [VALUE_WIDTH:0] s;
        s = sub ? ({a[VALUE_WIDTH-1], a} - {b[VALUE_WIDTH-1], b})
                : ({a[VALUE_WIDTH-1], a} + {b[VALUE_WIDTH-1], b});
        if (s[VALUE_WIDTH] != s[VALUE_WIDTH-1]) begin
            return s[VALUE_WIDTH] ? VMIN : VMAX;
        end
        return value_t'(s[VALUE_WIDTH-1:0]);
    endfunction

    function automatic value_t clamp_sym(value_t x, gain_t bound);
        value_t hi;
        value_t lo;
        value_t r;
        hi = value_t'(bound);
        lo = -hi;
        r  = x;
        if (r < lo) r = lo;
        if (r > hi) r = hi;
        return r;
    endfunction

endpackage

### rtl/sswpi_cfg.sv
// Configuration register bank of the skid-steer wheel PI controller, APB-style port.
// Depends on sswpi_pkg.
module sswpi_cfg (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [sswpi_pkg::CFG_ADDR_WIDTH-1:0] paddr,
    input  logic [sswpi_pkg::CFG_DATA_WIDTH-1:0] pwdata,
    output logic [sswpi_pkg::CFG_DATA_WIDTH-1:0] prdata,
    output logic                                pready,
    output sswpi_pkg::cfg_t                     cfg,
    output logic                                ki_zero
);

    sswpi_pkg::cfg_t     cfg_reg;
    sswpi_pkg::reg_idx_t idx;
    logic                wr_en;

    assign pready  = 1'b1;
    assign idx     = sswpi_pkg::reg_idx_t'(paddr[sswpi_pkg::CFG_ADDR_WIDTH-1:2]);
    assign wr_en   = psel & penable & pwrite & pready;
    assign cfg     = cfg_reg;
    assign ki_zero = (cfg_reg.ki == '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.kp          <= '0;
            cfg_reg.ki          <= '0;
            cfg_reg.ilow        <= '0;
            cfg_reg.ihigh       <= '0;
            cfg_reg.effort      <= sswpi_pkg::ONE_Q;
            cfg_reg.lin_scale   <= sswpi_pkg::ONE_Q;
            cfg_reg.turn_scale  <= sswpi_pkg::ONE_Q;
            cfg_reg.wheel_bound <= sswpi_pkg::WHEEL_RESET;
        end else if (wr_en) begin
            unique case (idx)
                sswpi_pkg::REG_KP:     cfg_reg.kp <= pwdata[sswpi_pkg::GAIN_WIDTH-1:0];
                sswpi_pkg::REG_KI:     cfg_reg.ki <= pwdata[sswpi_pkg::GAIN_WIDTH-1:0];
                sswpi_pkg::REG_ILOW:   cfg_reg.ilow <= sswpi_pkg::value_t'(pwdata);
                sswpi_pkg::REG_IHIGH:  cfg_reg.ihigh <= pwdata[sswpi_pkg::GAIN_WIDTH-1:0];
                sswpi_pkg::REG_EFFORT: cfg_reg.effort <= pwdata[sswpi_pkg::GAIN_WIDTH-1:0];
                sswpi_pkg::REG_LIN:    cfg_reg.lin_scale <= pwdata[sswpi_pkg::GAIN_WIDTH-1:0];
                sswpi_pkg::REG_TURN:   cfg_reg.turn_scale <= pwdata[sswpi_pkg::GAIN_WIDTH-1:0];
                sswpi_pkg::REG_WSB:    cfg_reg.wheel_bound <= pwdata[sswpi_pkg::GAIN_WIDTH-1:0];
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            sswpi_pkg::REG_KP:     prdata = sswpi_pkg::CFG_DATA_WIDTH'(cfg_reg.kp);
            sswpi_pkg::REG_KI:     prdata = sswpi_pkg::CFG_DATA_WIDTH'(cfg_reg.ki);
            sswpi_pkg::REG_ILOW:   prdata = sswpi_pkg::CFG_DATA_WIDTH'(unsigned'(cfg_reg.ilow));
            sswpi_pkg::REG_IHIGH:  prdata = sswpi_pkg::CFG_DATA_WIDTH'(cfg_reg.ihigh);
            sswpi_pkg::REG_EFFORT: prdata = sswpi_pkg::CFG_DATA_WIDTH'(cfg_reg.effort);
            sswpi_pkg::REG_LIN:    prdata = sswpi_pkg::CFG_DATA_WIDTH'(cfg_reg.lin_scale);
            sswpi_pkg::REG_TURN:   prdata = sswpi_pkg::CFG_DATA_WIDTH'(cfg_reg.turn_scale);
            sswpi_pkg::REG_WSB:    prdata = sswpi_pkg::CFG_DATA_WIDTH'(cfg_reg.wheel_bound);
        endcase
    end

endmodule

### rtl/sswpi_seq.sv
// Microcode sequencer: step counter, wheel counter, ROM fetch, jumps and stream handshakes.
// Depends on sswpi_pkg.
module sswpi_seq (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    output logic                m_tvalid,
    input  logic                m_tready,
    input  logic                ki_zero,
    output sswpi_pkg::dp_ctrl_t ctrl
);

    sswpi_pkg::state_t state_reg, state_next;
    sswpi_pkg::step_t  step_reg, step_next;
    sswpi_pkg::wheel_t wheel_reg, wheel_next;
    logic              m_tvalid_reg, m_tvalid_next;
    sswpi_pkg::uword_t uw;

    assign uw       = sswpi_pkg::ucode(step_reg);
    assign m_tvalid = m_tvalid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= sswpi_pkg::ST_IDLE;
            step_reg     <= '0;
            wheel_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            step_reg     <= step_next;
            wheel_reg    <= wheel_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_comb begin
        state_next    = state_reg;
        step_next     = step_reg;
        wheel_next    = wheel_reg;
        m_tvalid_next = m_tvalid_reg & ~m_tready;
        s_tready      = 1'b0;
        ctrl.uw       = sswpi_pkg::uw(sswpi_pkg::OP_NOP, sswpi_pkg::SRC_LIN, sswpi_pkg::SRC_LIN,
                                      sswpi_pkg::DST_NONE, sswpi_pkg::GAIN_KP, '0);
        ctrl.wheel    = wheel_reg;
        ctrl.start    = 1'b0;
        ctrl.load_out = 1'b0;
        unique case (state_reg)
            sswpi_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    ctrl.start = 1'b1;
                    state_next = sswpi_pkg::ST_RUN;
                    step_next  = '0;
                    wheel_next = '0;
                end
            end
            sswpi_pkg::ST_RUN: begin
                ctrl.uw   = uw;
                step_next = step_reg + 1'b1;
                case (uw.op)
                    sswpi_pkg::OP_JKIZ: begin
                        if (ki_zero) step_next = uw.target;
                    end
                    sswpi_pkg::OP_LOOP: begin
                        if (wheel_reg != sswpi_pkg::WHEEL_LAST) begin
                            wheel_next = wheel_reg + 1'b1;
                            step_next  = uw.target;
                        end
                    end
                    sswpi_pkg::OP_DONE: begin
                        step_next = step_reg;
                        // wait for the output register to free up
                        if (!m_tvalid_reg || m_tready) begin
                            ctrl.load_out = 1'b1;
                            m_tvalid_next = 1'b1;
                            state_next    = sswpi_pkg::ST_IDLE;
                        end
                    end
                    default: ;
                endcase
            end
        endcase
    end

endmodule

### rtl/sswpi_dp.sv
// Datapath: input capture, held state, shared multiplier with rounding, saturating ALU,
// output register. Driven one control word per cycle. Depends on sswpi_pkg.
module sswpi_dp (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  sswpi_pkg::dp_ctrl_t                 ctrl,
    input  sswpi_pkg::cfg_t                     cfg,
    input  logic [sswpi_pkg::IN_DATA_WIDTH-1:0] s_tdata,
    input  logic                                s_tuser,
    output logic [sswpi_pkg::OUT_DATA_WIDTH-1:0] m_tdata
);

    localparam int VW   = sswpi_pkg::VALUE_WIDTH;
    localparam int PW   = sswpi_pkg::PROD_WIDTH;
    localparam int QW   = PW + 1 - sswpi_pkg::FRACTION_BITS;
    localparam int NW   = sswpi_pkg::WHEEL_COUNT;
    localparam logic [QW-1:0] LIM_POS = {{(QW-VW+1){1'b0}}, {(VW-1){1'b1}}};
    localparam logic [QW-1:0] LIM_NEG = LIM_POS + 1'b1;
    localparam logic [PW:0]   RND_HALF = (PW+1)'(1) << (sswpi_pkg::FRACTION_BITS - 1);

    sswpi_pkg::value_t lin_reg, ang_reg;
    sswpi_pkg::value_t in_spd_reg [NW];
    logic              latch_reg;

    sswpi_pkg::value_t integ_reg [NW];
    sswpi_pkg::value_t spd_reg   [NW];
    sswpi_pkg::value_t tgt_reg   [2];
    sswpi_pkg::value_t torq_reg  [NW];

    sswpi_pkg::value_t a_reg, b_reg, t_reg, right_reg, left_reg, err_reg, p_reg;
    logic [PW-1:0]     prod_reg;
    logic              neg_reg;
    logic [sswpi_pkg::OUT_DATA_WIDTH-1:0] out_reg;

    logic              side;
    sswpi_pkg::value_t x_val, y_val, res, rnd_val, int_val;
    sswpi_pkg::gain_t  g_val;
    logic [VW-1:0]     mag_x;
    logic [PW:0]       rnd_sum;
    logic [QW-1:0]     q_raw, q_lim, q_sat;
    sswpi_pkg::op_t    op;
    sswpi_pkg::dst_t   dst;

    assign op      = ctrl.uw.op;
    assign dst     = ctrl.uw.dst;
    assign side    = !(ctrl.wheel == '0 || ctrl.wheel == sswpi_pkg::WHEEL_LAST);
    assign m_tdata = out_reg;

    always_comb begin
        case (ctrl.uw.src_x)
            sswpi_pkg::SRC_LIN:   x_val = lin_reg;
            sswpi_pkg::SRC_ANG:   x_val = ang_reg;
            sswpi_pkg::SRC_A:     x_val = a_reg;
            sswpi_pkg::SRC_B:     x_val = b_reg;
            sswpi_pkg::SRC_T:     x_val = t_reg;
            sswpi_pkg::SRC_ERR:   x_val = err_reg;
            sswpi_pkg::SRC_P:     x_val = p_reg;
            sswpi_pkg::SRC_INTEG: x_val = integ_reg[ctrl.wheel];
            sswpi_pkg::SRC_TGT:   x_val = tgt_reg[side];
            sswpi_pkg::SRC_SPD:   x_val = spd_reg[ctrl.wheel];
            default:              x_val = lin_reg;
        endcase
        case (ctrl.uw.src_y)
            sswpi_pkg::SRC_B:     y_val = b_reg;
            sswpi_pkg::SRC_T:     y_val = t_reg;
            sswpi_pkg::SRC_INTEG: y_val = integ_reg[ctrl.wheel];
            sswpi_pkg::SRC_SPD:   y_val = spd_reg[ctrl.wheel];
            default:              y_val = lin_reg;
        endcase
        unique case (ctrl.uw.gain)
            sswpi_pkg::GAIN_KP:   g_val = cfg.kp;
            sswpi_pkg::GAIN_KI:   g_val = cfg.ki;
            sswpi_pkg::GAIN_LIN:  g_val = cfg.lin_scale;
            sswpi_pkg::GAIN_TURN: g_val = cfg.turn_scale;
        endcase
    end

    // sign-magnitude product, rounded half away from zero in the following step
    assign mag_x   = x_val[VW-1] ? (~x_val + 1'b1) : x_val;
    assign rnd_sum = (PW+1)'(prod_reg) + RND_HALF;
    assign q_raw   = rnd_sum[PW:sswpi_pkg::FRACTION_BITS];
    assign q_lim   = neg_reg ? LIM_NEG : LIM_POS;
    assign q_sat   = (q_raw > q_lim) ? q_lim : q_raw;
    assign rnd_val = neg_reg ? sswpi_pkg::value_t'(~q_sat[VW-1:0] + 1'b1)
                             : sswpi_pkg::value_t'(q_sat[VW-1:0]);

    always_comb begin
        int_val = x_val;
        if (int_val < cfg.ilow) int_val = cfg.ilow;
        if (int_val > sswpi_pkg::value_t'(cfg.ihigh)) int_val = sswpi_pkg::value_t'(cfg.ihigh);
    end

    always_comb begin
        case (op)
            sswpi_pkg::OP_RND:    res = rnd_val;
            sswpi_pkg::OP_ADD:    res = sswpi_pkg::sat_add(x_val, y_val, 1'b0);
            sswpi_pkg::OP_SUB:    res = sswpi_pkg::sat_add(x_val, y_val, 1'b1);
            sswpi_pkg::OP_CLAMPW: res = sswpi_pkg::clamp_sym(x_val, cfg.wheel_bound);
            sswpi_pkg::OP_CLAMPE: res = sswpi_pkg::clamp_sym(x_val, cfg.effort);
            sswpi_pkg::OP_CLAMPI: res = int_val;
            default:              res = x_val;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (ctrl.start) begin
            lin_reg   <= sswpi_pkg::value_t'(s_tdata[VW-1:0]);
            ang_reg   <= sswpi_pkg::value_t'(s_tdata[2*VW-1:VW]);
            latch_reg <= s_tuser;
            for (int i = 0; i < NW; i++) begin
                in_spd_reg[i] <= sswpi_pkg::value_t'(s_tdata[(i+2)*VW +: VW]);
            end
        end
        if (op == sswpi_pkg::OP_MUL) begin
            prod_reg <= PW'(g_val) * PW'(mag_x);
            neg_reg  <= x_val[VW-1];
        end
        case (dst)
            sswpi_pkg::DST_A:     a_reg <= res;
            sswpi_pkg::DST_B:     b_reg <= res;
            sswpi_pkg::DST_T:     t_reg <= res;
            sswpi_pkg::DST_RIGHT: right_reg <= res;
            sswpi_pkg::DST_LEFT:  left_reg <= res;
            sswpi_pkg::DST_ERR:   err_reg <= res;
            sswpi_pkg::DST_P:     p_reg <= res;
            sswpi_pkg::DST_TORQ:  torq_reg[ctrl.wheel] <= res;
            default: ;
        endcase
        if (ctrl.load_out) begin
            out_reg <= {tgt_reg[1], tgt_reg[0],
                        integ_reg[3], integ_reg[2], integ_reg[1], integ_reg[0],
                        torq_reg[3], torq_reg[2], torq_reg[1], torq_reg[0]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NW; i++) begin
                integ_reg[i] <= '0;
                spd_reg[i]   <= '0;
            end
            tgt_reg[0] <= '0;
            tgt_reg[1] <= '0;
        end else begin
            if (dst == sswpi_pkg::DST_INTEG) integ_reg[ctrl.wheel] <= res;
            if (op == sswpi_pkg::OP_LATCH && latch_reg) begin
                tgt_reg[0] <= right_reg;
                tgt_reg[1] <= left_reg;
                for (int i = 0; i < NW; i++) begin
                    spd_reg[i] <= in_spd_reg[i];
                end
            end
        end
    end

endmodule

### rtl/skid_steer_wheel_pi_controller.sv
// Top level of the skid-steer wheel PI controller: sequencer, datapath, register bank.
// Depends on sswpi_pkg, sswpi_cfg, sswpi_seq, sswpi_dp.
//
// channel   direction  ports                        contents
// s_        in         tvalid tready tdata tuser    body command, wheel speeds, latch flag
// m_        out        tvalid tready tdata          torques, integral terms, held targets
// apb       in/out     psel penable pwrite paddr    eight configuration registers
//
// The microcode runs one step per cycle, stalling only at its last step, through one shared
// multiplier and one saturating ALU, eleven steps per wheel (seven without integral update,
// when the integral step gain is zero).
// Reset is synchronous, active low; registers take their reset values, held state is zero.
// A finished result waits in the output register; a new request is accepted meanwhile,
// and the sequencer stalls at its last step until the previous result is taken.
module skid_steer_wheel_pi_controller (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // linear_command, angular_command, speed_front_right, speed_front_left,
    // speed_rear_left, speed_rear_right
    input  logic [sswpi_pkg::IN_DATA_WIDTH-1:0]  s_tdata,
    // latch_measure
    input  logic [0:0]                           s_tuser,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // torque_front_right, torque_front_left, torque_rear_left, torque_rear_right,
    // integral_front_right, integral_front_left, integral_rear_left, integral_rear_right,
    // held_right_target, held_left_target
    output logic [sswpi_pkg::OUT_DATA_WIDTH-1:0] m_tdata,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [sswpi_pkg::CFG_ADDR_WIDTH-1:0] paddr,
    input  logic [sswpi_pkg::CFG_DATA_WIDTH-1:0] pwdata,
    output logic [sswpi_pkg::CFG_DATA_WIDTH-1:0] prdata,
    output logic                                 pready
);

    sswpi_pkg::cfg_t     cfg;
    sswpi_pkg::dp_ctrl_t ctrl;
    logic                ki_zero;

    sswpi_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg),
        .ki_zero (ki_zero)
    );

    sswpi_seq u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .ki_zero  (ki_zero),
        .ctrl     (ctrl)
    );

    sswpi_dp u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (ctrl),
        .cfg     (cfg),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser[0]),
        .m_tdata (m_tdata)
    );

endmodule

### tb/wheel_torque_checker.sv
// Checker for the skid-steer wheel PI controller: follows register writes and requests,
// predicts torques, integral terms and held targets per tick and compares each result.
// Depends on sswpi_pkg.
module wheel_torque_checker (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_tvalid,
    input  logic                                 s_tready,
    // linear_command, angular_command, speed_front_right, speed_front_left,
    // speed_rear_left, speed_rear_right
    input  logic [sswpi_pkg::IN_DATA_WIDTH-1:0]  s_tdata,
    // latch_measure
    input  logic [0:0]                           s_tuser,
    input  logic                                 m_tvalid,
    input  logic                                 m_tready,
    // torques fr, fl, rl, rr; integral terms fr, fl, rl, rr; held right, left target
    input  logic [sswpi_pkg::OUT_DATA_WIDTH-1:0] m_tdata,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic                                 pready,
    input  logic [sswpi_pkg::CFG_ADDR_WIDTH-1:0] paddr,
    input  logic [sswpi_pkg::CFG_DATA_WIDTH-1:0] pwdata,
    output int                                   bad_fields,
    output int                                   pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import sswpi_pkg::*;

    localparam longint VHI = longint'(VMAX);
    localparam longint VLO = longint'(VMIN);
    localparam int FIELDS = 2 * WHEEL_COUNT + 2;

    typedef logic [OUT_DATA_WIDTH-1:0] tick_result_t;

    longint kp, ki_h, i_low, i_high, effort, lin_k, turn_k, wheel_lim;
    value_t integ_acc [WHEEL_COUNT];
    value_t held_spd  [WHEEL_COUNT];
    value_t held_tgt  [2];
    tick_result_t due_results [$];
    int errs = 0;
    int shown = 0;
    string field_name [FIELDS] = '{
        "torque_front_right", "torque_front_left", "torque_rear_left", "torque_rear_right",
        "integral_front_right", "integral_front_left", "integral_rear_left",
        "integral_rear_right", "held_right_target", "held_left_target"
    };

    assign bad_fields = errs;

    function automatic longint clip(longint v);
        if (v > VHI) return VHI;
        if (v < VLO) return VLO;
        return v;
    endfunction

    function automatic longint limit_sym(longint v, longint lim);
        if (v < -lim) v = -lim;
        if (v > lim) v = lim;
        return v;
    endfunction

    // Q product, rounded half away from zero, saturated
    function automatic longint qmul(longint gain, longint x);
        longint mag;
        longint q;
        mag = gain * (x < 0 ? -x : x);
        q = (mag + (longint'(1) << (FRACTION_BITS - 1))) >>> FRACTION_BITS;
        if (x < 0) begin
            if (q > VHI + 1) q = VHI + 1;
            return -q;
        end
        if (q > VHI) q = VHI;
        return q;
    endfunction

    function automatic longint field(logic [IN_DATA_WIDTH-1:0] d, int k);
        value_t v;
        v = d[k*VALUE_WIDTH +: VALUE_WIDTH];
        return v;
    endfunction

    function automatic tick_result_t predict_tick(logic [IN_DATA_WIDTH-1:0] d, logic latch);
        longint fwd, turn, right, left, tgt, err, p, acc, torq;
        tick_result_t r;
        int w;
        fwd   = qmul(lin_k, field(d, 0));
        turn  = qmul(turn_k, field(d, 1));
        right = limit_sym(clip(fwd + turn), wheel_lim);
        left  = limit_sym(clip(fwd - turn), wheel_lim);
        if (latch) begin
            held_tgt[0] = value_t'(right);
            held_tgt[1] = value_t'(left);
            for (w = 0; w < WHEEL_COUNT; w++) begin
                held_spd[w] = value_t'(field(d, 2 + w));
            end
        end
        for (w = 0; w < WHEEL_COUNT; w++) begin
            // right side drives front right and rear right
            if (w == 0 || w == WHEEL_COUNT - 1) tgt = held_tgt[0];
            else tgt = held_tgt[1];
            err = clip(tgt - longint'(held_spd[w]));
            p   = qmul(kp, err);
            acc = integ_acc[w];
            if (ki_h != 0) begin
                acc = clip(acc + qmul(ki_h, err));
                if (acc < i_low) acc = i_low;
                if (acc > i_high) acc = i_high;
                acc = clip(acc);
            end
            integ_acc[w] = value_t'(acc);
            torq = clip(limit_sym(clip(p + acc), effort));
            r[w*VALUE_WIDTH +: VALUE_WIDTH] = value_t'(torq);
            r[(WHEEL_COUNT + w)*VALUE_WIDTH +: VALUE_WIDTH] = value_t'(acc);
        end
        r[2*WHEEL_COUNT*VALUE_WIDTH +: VALUE_WIDTH]     = held_tgt[0];
        r[(2*WHEEL_COUNT + 1)*VALUE_WIDTH +: VALUE_WIDTH] = held_tgt[1];
        return r;
    endfunction

    task automatic report(string msg);
        errs++;
        if (shown < 10) begin
            shown++;
            $display("%s", msg);
        end
    endtask

    always @(posedge aclk) begin : watch
        tick_result_t want;
        reg_idx_t idx;
        value_t low_bits;
        value_t exp_v;
        value_t got_v;
        int f;
        if (!aresetn) begin
            kp        = 0;
            ki_h      = 0;
            i_low     = 0;
            i_high    = 0;
            effort    = ONE_Q;
            lin_k     = ONE_Q;
            turn_k    = ONE_Q;
            wheel_lim = WHEEL_RESET;
            for (f = 0; f < WHEEL_COUNT; f++) begin
                integ_acc[f] = '0;
                held_spd[f]  = '0;
            end
            held_tgt[0] = '0;
            held_tgt[1] = '0;
            due_results.delete();
            pending <= 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                idx = reg_idx_t'(paddr[CFG_ADDR_WIDTH-1:2]);
                case (idx)
                    REG_KP:     kp        = pwdata[GAIN_WIDTH-1:0];
                    REG_KI:     ki_h      = pwdata[GAIN_WIDTH-1:0];
                    REG_ILOW: begin
                        low_bits = pwdata;
                        i_low    = low_bits;
                    end
                    REG_IHIGH:  i_high    = pwdata[GAIN_WIDTH-1:0];
                    REG_EFFORT: effort    = pwdata[GAIN_WIDTH-1:0];
                    REG_LIN:    lin_k     = pwdata[GAIN_WIDTH-1:0];
                    REG_TURN:   turn_k    = pwdata[GAIN_WIDTH-1:0];
                    REG_WSB:    wheel_lim = pwdata[GAIN_WIDTH-1:0];
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                if (due_results.size() == 0) begin
                    report("mismatch: result with no request outstanding");
                end else begin
                    want = due_results.pop_front();
                    for (f = 0; f < FIELDS; f++) begin
                        exp_v = want[f*VALUE_WIDTH +: VALUE_WIDTH];
                        got_v = m_tdata[f*VALUE_WIDTH +: VALUE_WIDTH];
                        if (got_v !== exp_v) begin
                            report($sformatf("mismatch %s: expected %0d, got %0d",
                                             field_name[f], exp_v, got_v));
                        end
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                due_results = {due_results, predict_tick(s_tdata, s_tuser[0])};
            end
            pending <= due_results.size();
        end
    end

endmodule

### tb/tb_skid_steer_wheel_pi_controller.sv
// Testbench top for the skid-steer wheel PI controller: clock, reset, register writes,
// directed and random requests with random idling on both sides, and the verdict.
// Depends on sswpi_pkg, skid_steer_wheel_pi_controller and wheel_torque_checker.
module tb_skid_steer_wheel_pi_controller;
    timeunit 1ns;
    timeprecision 1ps;
    import sswpi_pkg::*;

    logic                      aclk;
    logic                      aresetn;
    logic                      s_tvalid;
    logic                      s_tready;
    logic [IN_DATA_WIDTH-1:0]  s_tdata;
    logic [0:0]                s_tuser;
    logic                      m_tvalid;
    logic                      m_tready;
    logic [OUT_DATA_WIDTH-1:0] m_tdata;
    logic                      psel;
    logic                      penable;
    logic                      pwrite;
    logic [CFG_ADDR_WIDTH-1:0] paddr;
    logic [CFG_DATA_WIDTH-1:0] pwdata;
    logic [CFG_DATA_WIDTH-1:0] prdata;
    logic                      pready;
    int                        bad_fields;
    int                        pending;
    bit                        calm = 1'b0;
    bit                        hold_req = 1'b0;

    skid_steer_wheel_pi_controller u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    wheel_torque_checker u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .pready     (pready),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .bad_fields (bad_fields),
        .pending    (pending)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        #1_500_000;
        $display("FAILED: results differ");
        $finish;
    end

    // result side: random stalls, long hold-off on request
    initial begin : sink
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (400) @(posedge aclk);
            end else if (!calm && $urandom_range(0, 2) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 40)) @(posedge aclk);
            end
        end
    end

    task automatic offer(value_t lin, value_t ang, value_t fr, value_t fl, value_t rl,
                         value_t rr, logic latch);
        if (!calm && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge aclk);
        end
        s_tdata  <= {rr, rl, fl, fr, ang, lin};
        s_tuser  <= latch;
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(reg_idx_t idx, logic [CFG_DATA_WIDTH-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic write_config(logic [31:0] kp, logic [31:0] ki, logic [31:0] ilow,
                                logic [31:0] ihigh, logic [31:0] eff, logic [31:0] lin,
                                logic [31:0] turn, logic [31:0] wsb);
        write_reg(REG_KP, kp);
        write_reg(REG_KI, ki);
        write_reg(REG_ILOW, ilow);
        write_reg(REG_IHIGH, ihigh);
        write_reg(REG_EFFORT, eff);
        write_reg(REG_LIN, lin);
        write_reg(REG_TURN, turn);
        write_reg(REG_WSB, wsb);
    endtask

    function automatic logic [31:0] pick_gain(int unsigned floor);
        case ($urandom_range(0, 7))
            0:       return floor;
            1:       return 32'h7fff_ffff;
            2:       return 32'hffff_ffff;
            3:       return $urandom;
            default: return $urandom_range(floor, 4 << FRACTION_BITS);
        endcase
    endfunction

    function automatic logic [31:0] pick_low();
        case ($urandom_range(0, 7))
            0:       return 32'h0;
            1:       return 32'h8000_0000;
            2:       return $urandom | 32'h8000_0000;
            3:       return $urandom_range(1, 2 << FRACTION_BITS);
            default: return 32'h0 - $urandom_range(0, 4 << FRACTION_BITS);
        endcase
    endfunction

    function automatic value_t pick_value();
        case ($urandom_range(0, 9))
            0:       return VMAX;
            1:       return VMIN;
            2:       return '0;
            3, 4:    return value_t'($urandom);
            default: return value_t'($urandom_range(0, 24 << FRACTION_BITS))
                            - value_t'(12 << FRACTION_BITS);
        endcase
    endfunction

    task automatic directed_checks();
        value_t one;
        one = value_t'(1 << FRACTION_BITS);
        write_config(32'd2 << FRACTION_BITS, 32'h4000, 32'h0 - (32'd3 << FRACTION_BITS),
                     32'd3 << FRACTION_BITS, 32'd5 << FRACTION_BITS, 32'd1 << FRACTION_BITS,
                     32'h8000, 32'd10 << FRACTION_BITS);
        offer(one, '0, '0, '0, '0, '0, 1'b1);
        offer(VMAX, VMAX, VMAX, VMIN, VMAX, VMIN, 1'b1);
        offer(VMIN, VMIN, VMIN, VMAX, VMIN, VMAX, 1'b1);
        offer(VMAX, VMIN, '0, value_t'(-1), value_t'(1), '0, 1'b1);
        // latch low: previous targets and speeds stay
        offer('0, '0, '0, '0, '0, '0, 1'b0);
        offer(VMIN, VMAX, VMAX, VMAX, VMAX, VMAX, 1'b0);
        offer(value_t'(-1), value_t'(1), value_t'(-1), value_t'(1), value_t'(-1),
              value_t'(1), 1'b1);
        // half-LSB products round away from zero
        offer('0, value_t'(1), '0, '0, '0, '0, 1'b1);
        offer('0, value_t'(-1), '0, '0, '0, '0, 1'b1);
        // integral runs into its upper bound
        offer(value_t'(8 << FRACTION_BITS), '0, VMIN, VMIN, VMIN, VMIN, 1'b1);
        repeat (2) offer('0, '0, '0, '0, '0, '0, 1'b0);
        drain();

        write_config(32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
                     32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
        offer(VMAX, VMIN, VMIN, VMAX, VMAX, VMIN, 1'b1);
        offer(VMIN, VMIN, VMAX, VMAX, VMIN, VMIN, 1'b1);
        drain();

        // zero integral gain: integral holds without clamping
        write_config(32'd1 << FRACTION_BITS, 32'h0, 32'h0 - (32'd1 << FRACTION_BITS),
                     32'd1 << FRACTION_BITS, 32'd4 << FRACTION_BITS, 32'd1 << FRACTION_BITS,
                     32'd1 << FRACTION_BITS, 32'd10 << FRACTION_BITS);
        offer(one, one, '0, '0, '0, '0, 1'b1);
        offer(value_t'(-3 << FRACTION_BITS), '0, one, one, one, one, 1'b1);
        drain();

        // crossed integral bounds: upper bound wins
        write_config(32'd1 << FRACTION_BITS, 32'd1 << FRACTION_BITS, 32'd2 << FRACTION_BITS,
                     32'd1 << FRACTION_BITS, 32'd4 << FRACTION_BITS, 32'd1 << FRACTION_BITS,
                     32'd1 << FRACTION_BITS, 32'd10 << FRACTION_BITS);
        offer(value_t'(-5 << FRACTION_BITS), '0, '0, '0, '0, '0, 1'b1);
        offer(value_t'(5 << FRACTION_BITS), one, '0, '0, '0, '0, 1'b1);
        drain();

        // zero effort bound: all torques zero
        write_reg(REG_EFFORT, 32'h0);
        offer(VMAX, one, VMIN, '0, VMAX, '0, 1'b1);
        offer(VMIN, VMIN, '0, VMAX, '0, VMIN, 1'b1);
        drain();
    endtask

    task automatic random_phase(int count);
        value_t lin;
        value_t ang;
        value_t sp [WHEEL_COUNT];
        int k;
        int w;
        write_config(pick_gain(0), pick_gain(0), pick_low(), pick_gain(0), pick_gain(1),
                     pick_gain(0), pick_gain(0), pick_gain(1));
        for (k = 0; k < count; k++) begin
            lin = pick_value();
            ang = pick_value();
            for (w = 0; w < WHEEL_COUNT; w++) begin
                if ($urandom_range(0, 1) == 0) sp[w] = pick_value();
                else sp[w] = lin + value_t'($urandom_range(0, 2 << FRACTION_BITS))
                             - value_t'(1 << FRACTION_BITS);
            end
            offer(lin, ang, sp[0], sp[1], sp[2], sp[3], $urandom_range(0, 9) < 6);
        end
        drain();
    endtask

    initial begin : stimulus
        int phase;
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= '0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        offer(value_t'(3 << FRACTION_BITS), value_t'(1 << FRACTION_BITS), '0, '0, '0, '0,
              1'b1);
        drain();
        directed_checks();
        for (phase = 0; phase < 10; phase++) begin
            if (phase == 3) begin
                // back-to-back requests against a long result stall
                calm     = 1'b1;
                hold_req = 1'b1;
            end
            if (phase == 9) calm = 1'b1;
            random_phase(163);
            if (phase == 3) calm = 1'b0;
        end
        repeat (70) @(posedge aclk);
        if (bad_fields == 0 && pending == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
